>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL of the decimal number scanner.
// Each macro expands to one labelled concurrent assertion with a synchronous check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (reset active low)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (reset active low)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/adns_pkg.sv
// Types and constants of the ASCII decimal number scanner.
// Used by adns_step, ascii_decimal_number_scanner and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adns_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_EN  = 4'd1;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned OFF_W = 16;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_SAT    = 2'd2
  } phase_e;

  // Scan state apart from the character count
  typedef struct packed {
    phase_e             phase;
    logic               neg;
    logic [VAL_W-1:0]   mag;
  } scan_t;

  // Result of one item
  typedef struct packed {
    logic               emit;
    logic [VAL_W-1:0]   value;
    logic               found;
    logic [OFF_W-1:0]   offset;
    logic               str_end;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/adns_step.sv
// Per-character scan step: next scan state and the optional result item.
// Purely combinational; depends on adns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adns_step #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic [7:0]            char_i,
  input  adns_pkg::scan_t       scan_i,
  input  logic [COUNT_BITS-1:0] cnt_i,
  input  logic [31:0]           max_value_i,
  input  logic                  signed_en_i,
  output adns_pkg::scan_t       scan_o,
  output logic [COUNT_BITS-1:0] cnt_o,
  output adns_pkg::res_t        res_o
);
  import adns_pkg::*;

  logic                  is_digit;
  logic                  is_nul;
  logic                  is_minus;
  logic [3:0]            digit;
  logic [VAL_W+3:0]      times_ten;
  logic                  ovf_next;
  logic                  ovf_first;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]           cnt_ext;
  logic [OFF_W-1:0]      offset;
  logic [VAL_W-1:0]      signed_val;

  // Character classes
  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_nul   = (char_i == CH_NUL);
  assign is_minus = signed_en_i && (char_i == CH_MINUS);
  assign digit    = 4'(char_i - CH_ZERO);

  // value*10 + digit as shift-and-add, compared against the limit
  assign times_ten = {1'b0, scan_i.mag, 3'b000} + {3'b000, scan_i.mag, 1'b0}
                   + {32'd0, digit};
  assign ovf_next  = times_ten > {4'd0, max_value_i};
  assign ovf_first = {28'd0, digit} > max_value_i;

  // Saturating character count, and offset clipped to the output width
  assign cnt_inc = (cnt_i == {COUNT_BITS{1'b1}}) ? cnt_i : cnt_i + COUNT_BITS'(1);
  assign cnt_ext = 32'(cnt_i);
  assign offset  = (cnt_ext > 32'(16'hFFFF)) ? 16'hFFFF : cnt_ext[OFF_W-1:0];

  assign signed_val = (signed_en_i && scan_i.neg) ? (VAL_W'(0) - scan_i.mag) : scan_i.mag;

  always_comb begin
    scan_o        = scan_i;
    cnt_o         = cnt_i;
    res_o.emit    = 1'b0;
    res_o.value   = '0;
    res_o.found   = 1'b0;
    res_o.offset  = '0;
    res_o.str_end = 1'b0;
    case (scan_i.phase)
      PH_DIGITS, PH_SAT: begin
        if (is_digit) begin
          // Accumulate, or swallow digits once saturated
          if (scan_i.phase == PH_DIGITS) begin
            if (ovf_next) begin
              scan_o.mag   = max_value_i;
              scan_o.phase = PH_SAT;
            end else begin
              scan_o.mag = times_ten[VAL_W-1:0];
            end
          end
          cnt_o = cnt_inc;
        end else begin
          // Number ends: emit it; the same character opens the next scan
          res_o.emit    = 1'b1;
          res_o.value   = signed_val;
          res_o.found   = 1'b1;
          res_o.offset  = offset;
          res_o.str_end = is_nul;
          scan_o.phase  = PH_SKIP;
          scan_o.mag    = '0;
          scan_o.neg    = is_minus;
          cnt_o         = is_nul ? '0 : COUNT_BITS'(1);
        end
      end
      default: begin
        // Skipping phase
        if (is_nul) begin
          res_o.emit    = 1'b1;
          res_o.str_end = 1'b1;
          scan_o.phase  = PH_SKIP;
          scan_o.neg    = 1'b0;
          scan_o.mag    = '0;
          cnt_o         = '0;
        end else begin
          if (is_digit) begin
            if (ovf_first) begin
              scan_o.mag   = max_value_i;
              scan_o.phase = PH_SAT;
            end else begin
              scan_o.mag   = VAL_W'(digit);
              scan_o.phase = PH_DIGITS;
            end
          end else if (is_minus) begin
            scan_o.neg = ~scan_i.neg;
          end else begin
            scan_o.neg = 1'b0;
          end
          cnt_o = cnt_inc;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/ascii_decimal_number_scanner.sv
// Top level of the ASCII decimal number scanner: handshakes, registers, config.
// Depends on adns_pkg, adns_step and assert_macros.svh.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-----------------------------------
//   in      | sink      | in_valid_i/in_stall_o   | char_code_i
//   out     | source    | out_valid_o/out_stall_i | value_bits_o found_o end_offset_o
//           |           |                         | string_end_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// One character per clock unless stalled; results go via input and result registers.
// The cycle time is set by the times-ten add and limit compare in adns_step.
// Reset (rst_ni, async, active low) clears the scan, the handshakes and the config.
// A held result only blocks characters that produce a result; others still pass.
// Config writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ascii_decimal_number_scanner #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      char_code_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [31:0]                     value_bits_o,
  output logic                            found_o,
  output logic [15:0]                     end_offset_o,
  output logic                            string_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [adns_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import adns_pkg::*;

  logic                  in_vld_q;
  logic [7:0]            char_q;
  scan_t                 scan_q, scan_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  res_t                  res_d, res_q;
  logic                  out_vld_q;
  logic [31:0]           max_value_q;
  logic                  signed_en_q;
  logic                  out_free;
  logic                  adv;
  logic                  in_take;

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= 32'hFFFF_FFFF;
      signed_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_MAX_VALUE) begin
        max_value_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_SIGNED_EN) begin
        signed_en_q <= cfg_data_i[0];
      end
    end
  end

  // Scan step on the registered item
  adns_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .char_i      (char_q),
    .scan_i      (scan_q),
    .cnt_i       (cnt_q),
    .max_value_i (max_value_q),
    .signed_en_i (signed_en_q),
    .scan_o      (scan_d),
    .cnt_o       (cnt_d),
    .res_o       (res_d)
  );

  // Flow control: item advances unless its result would hit a held output
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && (!res_d.emit || out_free);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_vld_q || adv) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q.phase <= PH_SKIP;
      scan_q.neg   <= 1'b0;
      scan_q.mag   <= '0;
      cnt_q        <= '0;
    end else if (adv) begin
      scan_q <= scan_d;
      cnt_q  <= cnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= adv && res_d.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && adv && res_d.emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign value_bits_o = res_q.value;
  assign found_o      = res_q.found;
  assign end_offset_o = res_q.offset;
  assign string_end_o = res_q.str_end;

  // Checks
  `ASSERT_IMPLIES(a_notfound_zero, clk_i, rst_ni, out_vld_q && !res_q.found, (res_q.value == '0) && (res_q.offset == '0) && res_q.str_end, "result without number must be zero and end of string")
  `ASSERT_IMPLIES(a_skip_mag_zero, clk_i, rst_ni, scan_q.phase == PH_SKIP, scan_q.mag == '0, "magnitude not cleared while skipping")
  `ASSERT_NEXT(a_nul_clears, clk_i, rst_ni, adv && res_d.emit && res_d.str_end, (scan_q.phase == PH_SKIP) && (cnt_q == '0) && !scan_q.neg, "end of string did not clear the scan")
  `ASSERT_IMPLIES(a_no_result_loss, clk_i, rst_ni, adv && res_d.emit, out_free, "result overwrote a held output")

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the ASCII decimal number scanner (ascii_decimal_number_scanner).
// Predicts each emitted number from the characters it accepts and checks every result field.
// Depends on adns_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module testbench;
  import adns_pkg::*;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_PRINTS = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

  // Extra character codes used by the stimulus
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_HIGH    = 8'hFF;

  typedef struct packed {
    logic [31:0] value;
    logic        found;
    logic [15:0] offset;
    logic        str_end;
  } number_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           char_code_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [31:0]          value_bits_o;
  logic                 found_o;
  logic [15:0]          end_offset_o;
  logic                 string_end_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  ascii_decimal_number_scanner #(
    .COUNT_BITS(COUNT_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_bits_o(value_bits_o),
    .found_o     (found_o),
    .end_offset_o(end_offset_o),
    .string_end_o(string_end_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Scanner prediction state and its copy of the registers
  phase_e             pr_phase;
  logic               pr_negative;
  logic [31:0]        pr_magnitude;
  logic [COUNT_W-1:0] pr_count;
  logic [31:0]        pr_limit;
  logic               pr_signed;

  number_t expected_numbers[$];

  int mismatches;
  int chars_sent;
  int results_checked;
  int settings_used;
  int idle_cycles;
  int hold_left;
  bit in_gaps;
  bit out_gaps;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic void clear_scan();
    pr_phase     = PH_SKIP;
    pr_negative  = 1'b0;
    pr_magnitude = '0;
    pr_count     = '0;
  endfunction

  function automatic void count_char();
    if (pr_count != '1) pr_count = pr_count + 1'b1;
  endfunction

  // A character seen while skipping towards the next number (never NUL)
  function automatic void skip_char(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    if (is_digit(c)) begin
      if ({24'd0, d} > pr_limit) begin
        pr_magnitude = pr_limit;
        pr_phase     = PH_SAT;
      end else begin
        pr_magnitude = {24'd0, d};
        pr_phase     = PH_DIGITS;
      end
    end else if (pr_signed && c == CH_MINUS) begin
      pr_negative = ~pr_negative;
    end else begin
      pr_negative = 1'b0;
    end
    count_char();
  endfunction

  // Advance the scan by one character; emit is set when a result is due
  function automatic void scan_char(input logic [7:0] c, output bit emit, output number_t nr);
    logic [63:0] grown;
    logic [7:0]  d;
    emit = 1'b0;
    nr   = '0;
    d    = c - CH_ZERO;
    if (pr_phase == PH_SKIP) begin
      if (c == CH_NUL) begin
        emit       = 1'b1;
        nr.str_end = 1'b1;
        clear_scan();
      end else begin
        skip_char(c);
      end
    end else if (is_digit(c)) begin
      if (pr_phase == PH_DIGITS) begin
        grown = {32'd0, pr_magnitude} * 64'd10 + {56'd0, d};
        if (grown > {32'd0, pr_limit}) begin
          pr_magnitude = pr_limit;
          pr_phase     = PH_SAT;
        end else begin
          pr_magnitude = grown[31:0];
        end
      end
      count_char();
    end else begin
      // number ends here; the same character opens the next scan
      emit       = 1'b1;
      nr.value   = (pr_signed && pr_negative) ? (32'd0 - pr_magnitude) : pr_magnitude;
      nr.found   = 1'b1;
      nr.offset  = pr_count;
      nr.str_end = (c == CH_NUL);
      clear_scan();
      if (c != CH_NUL) skip_char(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Predicts on accepted items and register writes, checks accepted results
  always @(posedge clk_i) begin : monitor
    bit      emit;
    number_t nr;
    number_t want;
    bit      busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        busy = 1'b1;
        scan_char(char_code_i, emit, nr);
        if (emit) expected_numbers.push_back(nr);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        busy = 1'b1;
        case (cfg_index_i)
          REG_MAX_VALUE: pr_limit = cfg_data_i;
          REG_SIGNED_EN: pr_signed = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        busy = 1'b1;
        results_checked++;
        if (expected_numbers.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", value_bits_o));
        end else begin
          want = expected_numbers.pop_front();
          check_field("value_bits", value_bits_o, want.value);
          check_field("found", {31'd0, found_o}, {31'd0, want.found});
          check_field("end_offset", {16'd0, end_offset_o}, {16'd0, want.offset});
          check_field("string_end", {31'd0, string_end_o}, {31'd0, want.str_end});
        end
      end
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
  end

  // Watchdog: too long without any handshake
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Result stall: random bursts, or a long hold when asked
  initial begin : stall_gen
    int burst;
    burst       = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (burst == 0 && out_gaps && $urandom_range(0, 4) == 0) burst = $urandom_range(1, 3);
        out_stall_i <= (burst != 0);
        if (burst != 0) burst--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------

  // Leaves valid high afterwards; wait_idle lowers it
  task automatic send_char(input logic [7:0] c);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Stop sending and wait for every outstanding number plus pipeline slack
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Upper data bits of the sign register are random; only bit 0 counts
  task automatic set_config(input logic [31:0] limit, input bit sgn);
    wait_idle();
    cfg_write(REG_MAX_VALUE, limit);
    cfg_write(REG_SIGNED_EN, ($urandom() & ~32'd1) | {31'd0, sgn});
    settings_used++;
  endtask

  function automatic logic [7:0] random_non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_digit(c));
    return c;
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, NUL handling and saturation at the default limit
  task automatic test_basics();
    send_char(CH_HIGH);
    send_text("/0:");
    send_char(CH_NUL);       // NUL while skipping
    send_text("99999999999");
    send_char(CH_NUL);       // NUL ends a saturated number
  endtask

  // Sign toggling, small limits, limit below the first digit, zero limit
  task automatic test_signs_and_limits();
    set_config(32'd100, 1'b1);
    send_text("--5-12-3,101 ");
    set_config(32'd5, 1'b0);
    send_text("-7 ");
    set_config(32'd0, 1'b1);
    send_text("0 -9");
    send_char(CH_NUL);
  endtask

  // Sign enable dropped mid-number, and a write to an unused index
  task automatic test_config_midscan();
    set_config(32'hFFFF_FFFF, 1'b1);
    send_text("-4");
    wait_idle();
    cfg_write(REG_SIGNED_EN, 32'd0);
    send_char(CH_SPACE);
    wait_idle();
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    cfg_write(REG_SIGNED_EN, 32'd1);
    send_text("-8-");
  endtask

  // Long result hold so the block fills, then a sender pause mid-stream
  task automatic test_backpressure();
    wait_idle();
    in_gaps   = 1'b0;
    out_gaps  = 1'b0;
    hold_left = 80;
    repeat (30) begin
      send_char(random_digit());
      send_char(CH_SPACE);
    end
    send_text("12 ");
    wait_idle();
    send_text("34 ");
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  // Mostly well-formed numbers with random prefixes and terminators, some noise
  task automatic run_random(input int count, input logic [31:0] limit, input bit sgn);
    int         first;
    int         ndig;
    logic [7:0] c;
    set_config(limit, sgn);
    first = chars_sent;
    while (chars_sent - first < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0:       c = CH_MINUS;
            1:       c = CH_SPACE;
            2:       c = CH_LOWER_A + 8'($urandom_range(0, 25));
            default: c = random_non_digit();
          endcase
          send_char(c);
        end
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        repeat (ndig) send_char(random_digit());
        case ($urandom_range(0, 9))
          0:       c = CH_NUL;
          1, 2:    c = CH_MINUS;
          3, 4:    c = CH_COMMA;
          5, 6:    c = random_non_digit();
          default: c = CH_SPACE;
        endcase
        send_char(c);
      end
    end
  endtask

  task automatic test_random();
    logic [31:0] limits[8];
    bit          signs[8];
    limits = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd9, 32'd1000, 32'h7FFF_FFFF,
               $urandom(), 32'($urandom_range(0, 65535))};
    signs  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    for (int i = 0; i < 8; i++) begin
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      run_random(145, limits[i], signs[i]);
    end
  endtask

  // A long run of filler before a number, so the offset counts well past a byte
  task automatic test_long_string();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    set_config(32'hFFFF_FFFF, 1'b0);
    repeat (300) send_char(CH_LOWER_A);
    send_text("7 ");
    send_char(CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    char_code_i     = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    mismatches      = 0;
    chars_sent      = 0;
    results_checked = 0;
    settings_used   = 1;
    idle_cycles     = 0;
    hold_left       = 0;
    in_gaps         = 1'b1;
    out_gaps        = 1'b1;
    pr_limit        = '1;
    pr_signed       = 1'b0;
    clear_scan();

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basics();
    test_signs_and_limits();
    test_config_midscan();
    test_backpressure();
    test_random();
    test_long_string();
    // quiet tail: no idling on either side
    run_random(120, 32'd999_999, 1'b1);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (expected_numbers.size() != 0)
      report_mismatch($sformatf("%0d numbers never arrived", expected_numbers.size()));
    $display("Scanned %0d characters into %0d checked results under %0d register settings,",
             chars_sent, results_checked, settings_used);
    $display("covering signs, saturation, string ends, back-pressure and long filler runs.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/adns_pkg.sv
rtl/adns_step.sv
rtl/ascii_decimal_number_scanner.sv
test/testbench.sv
